/* rtl/assert_macros.svh */
// Assertion macros used by the queue of the matrix builder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define TRS_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("trs assertion failed");
`define TRS_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("trs assertion failed");
`else
`define TRS_ASSERT(lbl, clk, rstn, prop)
`define TRS_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

/* rtl/trs_pkg.sv */
// Shared constants, types and fixed-point helpers of the matrix builder.
package trs_pkg;
	localparam int FRAC_BITS    = 16;
	localparam int ANGLE_BITS   = 16;
	localparam int CORDIC_STEPS = 30;
	localparam int CW           = 34;
	localparam int TW           = FRAC_BITS + 2;
	localparam int RW           = FRAC_BITS + 3;
	localparam int FRONT_LAT    = CORDIC_STEPS + 2;
	localparam int QDEPTH       = 16;
	localparam int QAW          = 4;

	localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

	localparam logic signed [CW-1:0] ATAN_PHASE [0:CORDIC_STEPS-1] = '{
		34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
		34'sd42667331, 34'sd21354465, 34'sd10679838, 34'sd5340245,
		34'sd2670163, 34'sd1335087, 34'sd667544, 34'sd333772,
		34'sd166886, 34'sd83443, 34'sd41722, 34'sd20861,
		34'sd10430, 34'sd5215, 34'sd2608, 34'sd1304,
		34'sd652, 34'sd326, 34'sd163, 34'sd81,
		34'sd41, 34'sd20, 34'sd10, 34'sd5,
		34'sd3, 34'sd1
	};

	localparam logic signed [2*RW-1:0] MUL_HALF = (2*RW)'(1) << (FRAC_BITS - 1);

	typedef struct packed {
		logic signed [TW-1:0] sx;
		logic signed [TW-1:0] cx;
		logic signed [TW-1:0] sy;
		logic signed [TW-1:0] cy;
		logic signed [TW-1:0] sz;
		logic signed [TW-1:0] cz;
	} trig_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] scale_x;
		logic signed [31:0] scale_y;
		logic signed [31:0] scale_z;
	} pose_t;

	typedef struct packed {
		logic space;
		logic avail;
	} qstat_t;

	// Fixed-point product rounded to nearest, halves toward plus infinity.
	function automatic logic signed [RW-1:0] fx_mul(input logic signed [RW-1:0] a,
		input logic signed [RW-1:0] b);
		logic signed [2*RW-1:0] p;
		p = a * b;
		p = p + MUL_HALF;
		return p[FRAC_BITS +: RW];
	endfunction
endpackage

/* rtl/trs_sincos.sv */
// Pipelined rotation-mode CORDIC giving the sine and cosine of one binary angle.
module trs_sincos (
	input  logic                             clk,
	input  logic [15:0]                      angle,
	output logic signed [trs_pkg::TW-1:0]    sin_q,
	output logic signed [trs_pkg::TW-1:0]    cos_q
);
	localparam int N  = trs_pkg::CORDIC_STEPS;
	localparam int CW = trs_pkg::CW;
	localparam logic signed [CW-1:0] FR_HALF = CW'(1) << (29 - trs_pkg::FRAC_BITS);
	localparam logic signed [CW-1:0] FR_ONE  = CW'(1) << trs_pkg::FRAC_BITS;
	localparam logic signed [CW-1:0] FR_MONE = -FR_ONE;

	logic [31:0] phase, rounded, resid;
	logic [1:0]  quad;
	logic signed [CW-1:0] x_q [0:N];
	logic signed [CW-1:0] y_q [0:N];
	logic signed [CW-1:0] z_q [0:N];
	logic [1:0]           quad_q [0:N];
	logic signed [CW-1:0] c_raw, s_raw;

	function automatic logic signed [trs_pkg::TW-1:0] to_frac(input logic signed [CW-1:0] v);
		logic signed [CW-1:0] t;
		logic signed [CW-1:0] r;
		t = v + FR_HALF;
		r = t >>> (30 - trs_pkg::FRAC_BITS);
		if (r > FR_ONE) begin
			r = FR_ONE;
		end else if (r < FR_MONE) begin
			r = FR_MONE;
		end
		return r[trs_pkg::TW-1:0];
	endfunction

	// The nearest quadrant is removed so the residual stays within 45 degrees.
	always_comb begin
		phase   = {angle[trs_pkg::ANGLE_BITS-1:0], {(32-trs_pkg::ANGLE_BITS){1'b0}}};
		rounded = phase + 32'h2000_0000;
		quad    = rounded[31:30];
		resid   = phase - {quad, 30'b0};
	end

	always_ff @(posedge clk) begin
		x_q[0]    <= trs_pkg::CORDIC_GAIN;
		y_q[0]    <= '0;
		z_q[0]    <= CW'($signed(resid));
		quad_q[0] <= quad;
		for (int i = 0; i < N; i++) begin
			if (!z_q[i][CW-1]) begin
				x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
				y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
				z_q[i+1] <= z_q[i] - trs_pkg::ATAN_PHASE[i];
			end else begin
				x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
				y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
				z_q[i+1] <= z_q[i] + trs_pkg::ATAN_PHASE[i];
			end
			quad_q[i+1] <= quad_q[i];
		end
	end

	always_comb begin
		case (quad_q[N])
			2'd0: begin c_raw = x_q[N];  s_raw = y_q[N];  end
			2'd1: begin c_raw = -y_q[N]; s_raw = x_q[N];  end
			2'd2: begin c_raw = -x_q[N]; s_raw = -y_q[N]; end
			default: begin c_raw = y_q[N]; s_raw = -x_q[N]; end
		endcase
	end

	always_ff @(posedge clk) begin
		sin_q <= to_frac(s_raw);
		cos_q <= to_frac(c_raw);
	end
endmodule

/* rtl/trs_front.sv */
// Front end: accepts poses and runs the three angle lanes of sine and cosine.
module trs_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pose_valid,
	output logic                 pose_ready,
	input  logic [15:0]          angle_x,
	input  logic [15:0]          angle_y,
	input  logic [15:0]          angle_z,
	input  trs_pkg::qstat_t      qstat,
	output logic                 accept,
	output logic                 trig_valid,
	output trs_pkg::trig_t       trig
);
	logic [trs_pkg::FRONT_LAT-1:0] vld_q;

	// A queue slot is reserved at accept, so the lanes never have to stall.
	assign pose_ready = qstat.space;
	assign accept     = pose_valid && qstat.space;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[trs_pkg::FRONT_LAT-2:0], accept};
		end
	end

	assign trig_valid = vld_q[trs_pkg::FRONT_LAT-1];

	trs_sincos u_lane_x (.clk(clk), .angle(angle_x), .sin_q(trig.sx), .cos_q(trig.cx));
	trs_sincos u_lane_y (.clk(clk), .angle(angle_y), .sin_q(trig.sy), .cos_q(trig.cy));
	trs_sincos u_lane_z (.clk(clk), .angle(angle_z), .sin_q(trig.sz), .cos_q(trig.cz));
endmodule

/* rtl/trs_queue.sv */
// Queue between front and back: pose words at accept, trig words on lane exit.
`include "assert_macros.svh"
module trs_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_pose,
	input  trs_pkg::pose_t   pose_in,
	input  logic             push_trig,
	input  trs_pkg::trig_t   trig_in,
	input  logic             pop,
	output trs_pkg::qstat_t  qstat,
	output trs_pkg::pose_t   pose_out,
	output trs_pkg::trig_t   trig_out
);
	localparam int AW = trs_pkg::QAW;

	trs_pkg::pose_t pose_mem [0:trs_pkg::QDEPTH-1];
	trs_pkg::trig_t trig_mem [0:trs_pkg::QDEPTH-1];
	logic [AW:0] alloc_wp_q, trig_wp_q, rd_q;
	logic [AW:0] alloc_cnt, ready_cnt;
	logic [AW:0] rd_next;

	assign alloc_cnt   = alloc_wp_q - rd_q;
	assign ready_cnt   = trig_wp_q - rd_q;
	assign qstat.space = alloc_cnt < (AW+1)'(trs_pkg::QDEPTH);
	assign qstat.avail = ready_cnt != '0;
	assign rd_next     = pop ? rd_q + 1'b1 : rd_q;

	always_ff @(posedge clk) begin
		if (push_pose) begin
			pose_mem[alloc_wp_q[AW-1:0]] <= pose_in;
		end
		if (push_trig) begin
			trig_mem[trig_wp_q[AW-1:0]] <= trig_in;
		end
	end

	// The head words are registered from the next read address. A pose is written long
	// before its angles, so only the trig word needs a bypass into the slot read next.
	always_ff @(posedge clk) begin
		pose_out <= pose_mem[rd_next[AW-1:0]];
		if (push_trig && trig_wp_q[AW-1:0] == rd_next[AW-1:0]) begin
			trig_out <= trig_in;
		end else begin
			trig_out <= trig_mem[rd_next[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alloc_wp_q <= '0;
			trig_wp_q  <= '0;
			rd_q       <= '0;
		end else begin
			if (push_pose) begin
				alloc_wp_q <= alloc_wp_q + 1'b1;
			end
			if (push_trig) begin
				trig_wp_q <= trig_wp_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
		end
	end

	`TRS_ASSERT_ALWAYS(a_alloc_bound, clk, alloc_cnt <= (AW+1)'(trs_pkg::QDEPTH))
	`TRS_ASSERT(a_ready_within_alloc, clk, arst_n, ready_cnt <= alloc_cnt)
	`TRS_ASSERT(a_pop_has_data, clk, arst_n, pop |-> ready_cnt != '0)
	`TRS_ASSERT(a_trig_has_slot, clk, arst_n, push_trig |-> ready_cnt < alloc_cnt)
endmodule

/* rtl/trs_back.sv */
// Back end: rotations, then one scaled row per unstalled cycle to the output register.
module trs_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  trs_pkg::qstat_t       qstat,
	input  trs_pkg::pose_t        pose_in,
	input  trs_pkg::trig_t        trig_in,
	output logic                  pop,
	output logic                  row_valid,
	input  logic                  row_ready,
	output logic [1:0]            row_index,
	output logic signed [31:0]    col0,
	output logic signed [31:0]    col1,
	output logic signed [31:0]    col2,
	output logic signed [31:0]    col3,
	output logic                  saturated,
	output logic                  last_row
);
	localparam int RW   = trs_pkg::RW;
	localparam int PW   = RW + 32;
	localparam int RESW = PW - trs_pkg::FRAC_BITS;
	localparam logic signed [PW-1:0] ROW_HALF = PW'(1) << (trs_pkg::FRAC_BITS - 1);

	logic a_vld_q, b_vld_q, out_vld_q;
	logic out_free, emit, b_free, a_free;
	trs_pkg::trig_t trig_s1;
	trs_pkg::pose_t pose_s1, pose_s2;
	logic signed [RW-1:0] sysx_s1, cysx_s1;
	logic signed [RW-1:0] r_s2 [0:2][0:2];
	logic signed [RW-1:0] r_c [0:2][0:2];
	logic signed [RW-1:0] sx, cx, sy, cy, sz, cz;
	logic [1:0] row_q;
	logic signed [RW-1:0] r_sel [0:2];
	logic signed [31:0] sc [0:2];
	logic signed [PW-1:0] prod [0:2];
	logic signed [RESW-1:0] res [0:2];
	logic signed [31:0] col_c [0:3];
	logic sat_c;

	assign out_free = !out_vld_q || row_ready;
	assign emit     = b_vld_q && out_free;
	assign b_free   = !b_vld_q || (emit && row_q == 2'd3);
	assign a_free   = !a_vld_q || b_free;
	assign pop      = qstat.avail && a_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_vld_q   <= 1'b0;
			b_vld_q   <= 1'b0;
			out_vld_q <= 1'b0;
			row_q     <= 2'd0;
		end else begin
			if (a_free) begin
				a_vld_q <= qstat.avail;
			end
			if (b_free) begin
				b_vld_q <= a_vld_q;
			end
			if (out_free) begin
				out_vld_q <= b_vld_q;
			end
			if (emit) begin
				row_q <= row_q + 2'd1;
			end
		end
	end

	// First stage: the two shared sine products.
	always_ff @(posedge clk) begin
		if (pop) begin
			trig_s1 <= trig_in;
			pose_s1 <= pose_in;
			sysx_s1 <= trs_pkg::fx_mul(RW'(trig_in.sy), RW'(trig_in.sx));
			cysx_s1 <= trs_pkg::fx_mul(RW'(trig_in.cy), RW'(trig_in.sx));
		end
	end

	always_comb begin
		sx = RW'(trig_s1.sx);
		cx = RW'(trig_s1.cx);
		sy = RW'(trig_s1.sy);
		cy = RW'(trig_s1.cy);
		sz = RW'(trig_s1.sz);
		cz = RW'(trig_s1.cz);
		r_c[0][0] = trs_pkg::fx_mul(cy, cz) + trs_pkg::fx_mul(sysx_s1, sz);
		r_c[0][1] = trs_pkg::fx_mul(sysx_s1, cz) - trs_pkg::fx_mul(cy, sz);
		r_c[0][2] = trs_pkg::fx_mul(sy, cx);
		r_c[1][0] = trs_pkg::fx_mul(cx, sz);
		r_c[1][1] = trs_pkg::fx_mul(cx, cz);
		r_c[1][2] = -sx;
		r_c[2][0] = trs_pkg::fx_mul(cysx_s1, sz) - trs_pkg::fx_mul(sy, cz);
		r_c[2][1] = trs_pkg::fx_mul(sy, sz) + trs_pkg::fx_mul(cysx_s1, cz);
		r_c[2][2] = trs_pkg::fx_mul(cy, cx);
	end

	// Second stage holds the rotation while its rows go out.
	always_ff @(posedge clk) begin
		if (b_free && a_vld_q) begin
			r_s2    <= r_c;
			pose_s2 <= pose_s1;
		end
	end

	always_comb begin
		sc[0] = pose_s2.scale_x;
		sc[1] = pose_s2.scale_y;
		sc[2] = pose_s2.scale_z;
		for (int j = 0; j < 3; j++) begin
			case (row_q)
				2'd0:    r_sel[j] = r_s2[0][j];
				2'd1:    r_sel[j] = r_s2[1][j];
				default: r_sel[j] = r_s2[2][j];
			endcase
		end
		sat_c = 1'b0;
		for (int j = 0; j < 3; j++) begin
			prod[j] = r_sel[j] * sc[j];
			prod[j] = prod[j] + ROW_HALF;
			res[j]  = prod[j][trs_pkg::FRAC_BITS +: RESW];
			if (!(&res[j][RESW-1:31]) && (|res[j][RESW-1:31])) begin
				col_c[j] = res[j][RESW-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
				sat_c    = 1'b1;
			end else begin
				col_c[j] = res[j][31:0];
			end
		end
		case (row_q)
			2'd0:    col_c[3] = pose_s2.pos_x;
			2'd1:    col_c[3] = pose_s2.pos_y;
			2'd2:    col_c[3] = pose_s2.pos_z;
			default: col_c[3] = 32'(1) << trs_pkg::FRAC_BITS;
		endcase
		if (row_q == 2'd3) begin
			col_c[0] = '0;
			col_c[1] = '0;
			col_c[2] = '0;
			sat_c    = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			row_index <= row_q;
			col0      <= col_c[0];
			col1      <= col_c[1];
			col2      <= col_c[2];
			col3      <= col_c[3];
			saturated <= sat_c;
			last_row  <= row_q == 2'd3;
		end
	end

	assign row_valid = out_vld_q;
endmodule

/* rtl/trs_model_matrix_builder_unit.sv */
// Top level of the model-matrix builder: front lanes, queue and row back end.
//
//   channel | direction | handshake              | payload
//   pose    | in        | pose_valid, pose_ready | pos_*, angle_*, scale_*
//   row     | out       | row_valid, row_ready   | row_index, col0..col3, saturated, last_row
//
// Each pose item yields four row items, one per cycle while row_ready does not stall
// the output; the single row multiplier stage of the back end sets the pose rate.
// The first row of a pose passes through the CORDIC lanes into the queue, then
// through the pop, rotation and output registers. arst_n clears all control state.
// The front takes a pose whenever the queue has a free slot, so a stalled row
// output only blocks input once the sixteen queue slots are all taken.
module trs_model_matrix_builder_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pose_valid,
	output logic               pose_ready,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [15:0] angle_x,
	input  logic signed [15:0] angle_y,
	input  logic signed [15:0] angle_z,
	input  logic signed [31:0] scale_x,
	input  logic signed [31:0] scale_y,
	input  logic signed [31:0] scale_z,
	output logic               row_valid,
	input  logic               row_ready,
	output logic [1:0]         row_index,
	output logic signed [31:0] col0,
	output logic signed [31:0] col1,
	output logic signed [31:0] col2,
	output logic signed [31:0] col3,
	output logic               saturated,
	output logic               last_row
);
	trs_pkg::qstat_t qstat;
	trs_pkg::pose_t  pose_in, pose_head;
	trs_pkg::trig_t  trig_lane, trig_head;
	logic accept, trig_valid, pop;

	// Position and scale skip the lanes and wait in the queue for their angles.
	always_comb begin
		pose_in.pos_x   = pos_x;
		pose_in.pos_y   = pos_y;
		pose_in.pos_z   = pos_z;
		pose_in.scale_x = scale_x;
		pose_in.scale_y = scale_y;
		pose_in.scale_z = scale_z;
	end

	trs_front u_front (
		.clk(clk), .arst_n(arst_n),
		.pose_valid(pose_valid), .pose_ready(pose_ready),
		.angle_x(angle_x), .angle_y(angle_y), .angle_z(angle_z),
		.qstat(qstat), .accept(accept),
		.trig_valid(trig_valid), .trig(trig_lane)
	);

	trs_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push_pose(accept), .pose_in(pose_in),
		.push_trig(trig_valid), .trig_in(trig_lane),
		.pop(pop), .qstat(qstat),
		.pose_out(pose_head), .trig_out(trig_head)
	);

	trs_back u_back (
		.clk(clk), .arst_n(arst_n),
		.qstat(qstat), .pose_in(pose_head), .trig_in(trig_head), .pop(pop),
		.row_valid(row_valid), .row_ready(row_ready),
		.row_index(row_index), .col0(col0), .col1(col1), .col2(col2), .col3(col3),
		.saturated(saturated), .last_row(last_row)
	);
endmodule
